### hw/rtl/bft_pkg.sv
// ----------------------------------------------------------------------------
// Flow table package
// Shared sizes, status codes and command/status types of the flow table.
// ----------------------------------------------------------------------------
package bft_pkg;

	localparam int unsigned BUCKETS   = 64;
	localparam int unsigned WAYS      = 4;
	localparam int unsigned MAX_FLOWS = 256;
	localparam int unsigned BKT_W     = $clog2(BUCKETS);
	localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned IDX_W     = $clog2(MAX_FLOWS);
	localparam int unsigned CNT_W     = $clog2(MAX_FLOWS + 1);

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_UDP     = 3'd1,
		ST_KILLED  = 3'd2,
		ST_OPENING = 3'd3,
		ST_CLOSING = 3'd4,
		ST_ACTIVE  = 3'd5,
		ST_CLOSED  = 3'd6
	} flow_st_t;

	localparam logic [1:0] PK_TCP = 2'd1;
	localparam logic [1:0] PK_UDP = 2'd2;

	typedef enum logic [1:0] {
		C_IDLE,
		C_LOOK,
		C_DONE
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic look;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic flush;
	} dp_sts_t;

	function automatic logic [2:0] tcp_next(logic [2:0] cur, logic [7:0] fl);
		logic [2:0] r;
		r = cur;
		if (fl[2]) r = ST_KILLED;
		else if (fl[1]) r = ST_OPENING;
		else if (fl[0]) r = ST_CLOSING;
		else if (fl[3]) r = ST_ACTIVE;
		else if (fl[4] && cur == ST_CLOSING) r = ST_CLOSED;
		return r;
	endfunction

endpackage

### hw/rtl/bft_ctrl.sv
// ----------------------------------------------------------------------------
// Flow table controller
// Sequences accept, bucket lookup with write-back, and result delivery.
// ----------------------------------------------------------------------------
module bft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bft_pkg::dp_sts_t  sts,
	output bft_pkg::dp_cmd_t  cmd
);
	import bft_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= C_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: begin
				if (in_valid) state_d = C_LOOK;
			end
			C_LOOK: state_d = C_DONE;
			C_DONE: begin
				if (out_ready) state_d = in_valid ? C_LOOK : C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			C_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			C_LOOK: begin
				cmd.look  = ~sts.flush;
				cmd.clear = sts.flush;
			end
			C_DONE: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				cmd.load  = out_ready & in_valid;
			end
			default: ;
		endcase
	end
endmodule

### hw/rtl/bft_dp.sv
// ----------------------------------------------------------------------------
// Flow table datapath
// Input latch, hash, bucket read, bucket compare, entry store and result.
// ----------------------------------------------------------------------------
module bft_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  bft_pkg::dp_cmd_t  cmd,
	output bft_pkg::dp_sts_t  sts,
	input  logic              func,
	input  logic [31:0]       src_addr,
	input  logic [31:0]       dst_addr,
	input  logic [15:0]       src_port,
	input  logic [15:0]       dst_port,
	input  logic [1:0]        proto_kind,
	input  logic [7:0]        tcp_flag_bits,
	output logic              hit,
	output logic [7:0]        flow_index,
	output logic [8:0]        flow_count,
	output logic [2:0]        flow_status,
	output logic              full_flag
);
	import bft_pkg::*;

	logic             func_q;
	logic [31:0]      sa_q, da_q;
	logic [15:0]      sp_q, dp_q;
	logic [1:0]       pk_q;
	logic [7:0]       fl_q;
	logic [BKT_W-1:0] bkt_q;
	logic [31:0]      sum;

	logic [BUCKETS*WAYS-1:0] valid_q;
	logic [31:0]      ksa_mem [BUCKETS][WAYS];
	logic [31:0]      kda_mem [BUCKETS][WAYS];
	logic [15:0]      ksp_mem [BUCKETS][WAYS];
	logic [15:0]      kdp_mem [BUCKETS][WAYS];
	logic [1:0]       kpk_mem [BUCKETS][WAYS];
	logic [IDX_W-1:0] kix_mem [BUCKETS][WAYS];
	logic [2:0]       kst_mem [BUCKETS][WAYS];
	logic [31:0]      rsa_q [WAYS];
	logic [31:0]      rda_q [WAYS];
	logic [15:0]      rsp_q [WAYS];
	logic [15:0]      rdp_q [WAYS];
	logic [1:0]       rpk_q [WAYS];
	logic [IDX_W-1:0] rix_q [WAYS];
	logic [2:0]       rst_q [WAYS];
	logic [CNT_W-1:0] cnt_q;

	logic [WAYS-1:0]  way_hit, way_free;
	logic [WAY_W-1:0] hit_w, free_w;
	logic             any_hit, any_free, can_ins;
	logic [IDX_W-1:0] hidx;
	logic [2:0]       new_st, cur_st;

	assign sum = src_addr + dst_addr + {16'd0, src_port} + {16'd0, dst_port};
	assign sts.flush = func_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			sa_q <= src_addr;
			da_q <= dst_addr;
			sp_q <= src_port;
			dp_q <= dst_port;
			pk_q <= proto_kind;
			fl_q <= tcp_flag_bits;
			bkt_q <= sum[BKT_W-1:0];
		end
	end

	always_comb begin
		way_hit = '0;
		way_free = '0;
		hit_w = '0;
		free_w = '0;
		any_hit = 1'b0;
		any_free = 1'b0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			way_free[w] = ~valid_q[{bkt_q, WAY_W'(w)}];
			way_hit[w] = ~way_free[w] && rpk_q[w] == pk_q &&
				((rsa_q[w] == sa_q && rda_q[w] == da_q &&
				  rsp_q[w] == sp_q && rdp_q[w] == dp_q) ||
				 (rda_q[w] == sa_q && rsa_q[w] == da_q &&
				  rdp_q[w] == sp_q && rsp_q[w] == dp_q));
			if (way_hit[w]) begin
				hit_w = WAY_W'(w);
				any_hit = 1'b1;
			end
			if (way_free[w]) begin
				free_w = WAY_W'(w);
				any_free = 1'b1;
			end
		end
	end

	assign hidx    = rix_q[hit_w];
	assign cur_st  = rst_q[hit_w];
	assign can_ins = any_free && (cnt_q < CNT_W'(MAX_FLOWS));
	always_comb begin
		if (any_hit) new_st = (pk_q == PK_TCP) ? tcp_next(cur_st, fl_q) : cur_st;
		else if (pk_q == PK_TCP) new_st = tcp_next(ST_NONE, fl_q);
		else if (pk_q == PK_UDP) new_st = ST_UDP;
		else new_st = ST_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q <= '0;
		end else if (cmd.look) begin
			if (!any_hit && can_ins) begin
				valid_q[{bkt_q, free_w}] <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (cmd.clear) begin
			valid_q <= '0;
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			if (any_hit) begin
				kst_mem[bkt_q][hit_w] <= new_st;
			end else if (can_ins) begin
				ksa_mem[bkt_q][free_w] <= sa_q;
				kda_mem[bkt_q][free_w] <= da_q;
				ksp_mem[bkt_q][free_w] <= sp_q;
				kdp_mem[bkt_q][free_w] <= dp_q;
				kpk_mem[bkt_q][free_w] <= pk_q;
				kix_mem[bkt_q][free_w] <= cnt_q[IDX_W-1:0];
				kst_mem[bkt_q][free_w] <= new_st;
			end
		end
		if (cmd.load) begin
			for (int w = 0; w < WAYS; w++) begin
				rsa_q[w] <= ksa_mem[sum[BKT_W-1:0]][w];
				rda_q[w] <= kda_mem[sum[BKT_W-1:0]][w];
				rsp_q[w] <= ksp_mem[sum[BKT_W-1:0]][w];
				rdp_q[w] <= kdp_mem[sum[BKT_W-1:0]][w];
				rpk_q[w] <= kpk_mem[sum[BKT_W-1:0]][w];
				rix_q[w] <= kix_mem[sum[BKT_W-1:0]][w];
				rst_q[w] <= kst_mem[sum[BKT_W-1:0]][w];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			if (any_hit) begin
				hit <= 1'b1;
				flow_index <= 8'(hidx);
				flow_status <= new_st;
				flow_count <= 9'(cnt_q);
				full_flag <= 1'b0;
			end else if (can_ins) begin
				hit <= 1'b0;
				flow_index <= 8'(cnt_q[IDX_W-1:0]);
				flow_status <= new_st;
				flow_count <= 9'(cnt_q + 1'b1);
				full_flag <= 1'b0;
			end else begin
				hit <= 1'b0;
				flow_index <= '0;
				flow_status <= ST_NONE;
				flow_count <= 9'(cnt_q);
				full_flag <= 1'b1;
			end
		end else if (cmd.clear) begin
			hit <= 1'b0;
			flow_index <= '0;
			flow_status <= ST_NONE;
			flow_count <= '0;
			full_flag <= 1'b0;
		end
	end
endmodule

### hw/rtl/bidirectional_flow_table_core.sv
// ----------------------------------------------------------------------------
// Bidirectional flow table core
// Hashed connection tracker with per-flow TCP status.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one packet header or a
// flush command per beat. Each beat yields exactly one result beat on the
// output channel (out_valid/out_ready).
// The header is latched into input registers, compared in the lookup state and
// its result is registered and presented in the done state.
// The bucket row, with keys, flow indexes and status of its ways, is read
// into registers at the accepting edge; the compare and the write-back of a
// new entry or status happen in the following lookup cycle.
// The core takes no new beat before the previous result is taken; the next
// beat is accepted at the edge where the result is taken.
// A flush clears all valid bits and the flow count in its lookup cycle.
// Reset empties the table and the count; no clearing pass is needed.
// While the receiver stalls, the result holds and no beat is accepted.
// ----------------------------------------------------------------------------
module bidirectional_flow_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [1:0]  proto_kind,
	input  logic [7:0]  tcp_flag_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [7:0]  flow_index,
	output logic [8:0]  flow_count,
	output logic [2:0]  flow_status,
	output logic        full_flag
);
	import bft_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bft_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd
	);

	bft_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .func, .src_addr, .dst_addr, .src_port,
		.dst_port, .proto_kind, .tcp_flag_bits, .hit, .flow_index,
		.flow_count, .flow_status, .full_flag
	);
endmodule

### hw/rtl/bft_checker.sv
// ----------------------------------------------------------------------------
// Flow table port checker
// Port-level checks over time, bound to the core.
// ----------------------------------------------------------------------------
module bft_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       hit,
	input logic [8:0] flow_count,
	input logic       full_flag
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(flow_count))
		else $error("result changed while stalled");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit && full_flag && out_valid))
		else $error("hit and full together");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("result not presented");
	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flow_count <= 9'd256)
		else $error("count out of range");
endmodule

bind bidirectional_flow_table_core bft_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.hit, .flow_count, .full_flag
);

### tb/bft_flow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table result checker
// Watches both channels of the flow table core. It keeps its own copy of the
// buckets, keys and per-flow status, predicts one result for every accepted
// header or flush, and compares each accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module bft_flow_checker
	import bft_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [1:0]  proto_kind,
	input  logic [7:0]  tcp_flag_bits,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        hit,
	input  logic [7:0]  flow_index,
	input  logic [8:0]  flow_count,
	input  logic [2:0]  flow_status,
	input  logic        full_flag,
	output int          fails,
	output int          pending
);

	localparam int SLOTS = BUCKETS * WAYS;

	typedef struct packed {
		logic       hit;
		logic [7:0] idx;
		logic [8:0] cnt;
		logic [2:0] st;
		logic       full;
	} lookup_t;

	logic             slot_used [SLOTS];
	logic [31:0]      slot_sa   [SLOTS];
	logic [31:0]      slot_da   [SLOTS];
	logic [15:0]      slot_sp   [SLOTS];
	logic [15:0]      slot_dp   [SLOTS];
	logic [1:0]       slot_pk   [SLOTS];
	logic [IDX_W-1:0] slot_idx  [SLOTS];
	logic [2:0]       flow_st   [MAX_FLOWS];
	logic [CNT_W-1:0] flows_held;
	lookup_t          lookups_due[$];

	function automatic logic [2:0] advance_tcp_status(logic [2:0] cur, logic [7:0] fl);
		if (fl[2]) return ST_KILLED;
		if (fl[1]) return ST_OPENING;
		if (fl[0]) return ST_CLOSING;
		if (fl[3]) return ST_ACTIVE;
		if (fl[4] && cur == ST_CLOSING) return ST_CLOSED;
		return cur;
	endfunction

	function automatic lookup_t track_header();
		lookup_t     r;
		logic [31:0] sum;
		int          base, s, free_slot;
		logic [2:0]  nst;
		r = '0;
		free_slot = -1;
		if (func) begin
			for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
			flows_held = '0;
			return r;
		end
		sum = src_addr + dst_addr + src_port + dst_port;
		base = (sum % BUCKETS) * WAYS;
		for (int w = 0; w < WAYS; w++) begin
			s = base + w;
			if (!slot_used[s]) begin
				if (free_slot < 0) free_slot = s;
			end else if (slot_pk[s] == proto_kind &&
				((slot_sa[s] == src_addr && slot_da[s] == dst_addr &&
				  slot_sp[s] == src_port && slot_dp[s] == dst_port) ||
				 (slot_da[s] == src_addr && slot_sa[s] == dst_addr &&
				  slot_dp[s] == src_port && slot_sp[s] == dst_port))) begin
				if (proto_kind == PK_TCP)
					flow_st[slot_idx[s]] = advance_tcp_status(flow_st[slot_idx[s]],
						tcp_flag_bits);
				r.hit = 1'b1;
				r.idx = slot_idx[s];
				r.cnt = flows_held;
				r.st = flow_st[slot_idx[s]];
				return r;
			end
		end
		if (free_slot < 0 || flows_held >= MAX_FLOWS) begin
			r.cnt = flows_held;
			r.full = 1'b1;
			return r;
		end
		slot_used[free_slot] = 1'b1;
		slot_sa[free_slot] = src_addr;
		slot_da[free_slot] = dst_addr;
		slot_sp[free_slot] = src_port;
		slot_dp[free_slot] = dst_port;
		slot_pk[free_slot] = proto_kind;
		slot_idx[free_slot] = flows_held[IDX_W-1:0];
		if (proto_kind == PK_TCP) nst = advance_tcp_status(ST_NONE, tcp_flag_bits);
		else if (proto_kind == PK_UDP) nst = ST_UDP;
		else nst = ST_NONE;
		flow_st[flows_held[IDX_W-1:0]] = nst;
		r.idx = flows_held[IDX_W-1:0];
		flows_held = flows_held + 1'b1;
		r.cnt = flows_held;
		r.st = nst;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t e;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
			flows_held = '0;
			lookups_due.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (lookups_due.size() == 0) begin
					$error("result beat with no prediction waiting");
					fails = fails + 1;
				end else begin
					e = lookups_due.pop_front();
					if (hit !== e.hit) begin
						$error("hit expected %0d actual %0d", e.hit, hit);
						fails = fails + 1;
					end
					if (flow_index !== e.idx) begin
						$error("flow_index expected %0d actual %0d", e.idx, flow_index);
						fails = fails + 1;
					end
					if (flow_count !== e.cnt) begin
						$error("flow_count expected %0d actual %0d", e.cnt, flow_count);
						fails = fails + 1;
					end
					if (flow_status !== e.st) begin
						$error("flow_status expected %0d actual %0d", e.st, flow_status);
						fails = fails + 1;
					end
					if (full_flag !== e.full) begin
						$error("full_flag expected %0d actual %0d", e.full, full_flag);
						fails = fails + 1;
					end
				end
			end
			if (in_valid && in_ready) lookups_due.push_back(track_header());
			pending = lookups_due.size();
		end
	end

endmodule

### tb/tb_bidirectional_flow_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table core testbench
// Drives directed headers (table fill, full table, flag sequences, extremes)
// and then random traffic built mostly from repeated and reversed flows,
// under several idle and stall mixes with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_bidirectional_flow_table_core;
	import bft_pkg::*;

	typedef struct {
		logic        fn;
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [1:0]  pk;
		logic [7:0]  fl;
	} header_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic [31:0] src_addr = '0;
	logic [31:0] dst_addr = '0;
	logic [15:0] src_port = '0;
	logic [15:0] dst_port = '0;
	logic [1:0]  proto_kind = '0;
	logic [7:0]  tcp_flag_bits = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        hit;
	logic [7:0]  flow_index;
	logic [8:0]  flow_count;
	logic [2:0]  flow_status;
	logic        full_flag;
	int          fails;
	int          pending;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	header_t     flow_pool[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bidirectional_flow_table_core dut (.*);

	bft_flow_checker checker_i (.*);

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			hold_left <= 400;
			hold_req = 0;
		end else begin
			out_ready <= ($urandom % 100) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (arst_n && quiet_cycles >= 5000) begin
			$display("bidirectional_flow_table_core: mismatch");
			$finish;
		end
	end

	task automatic offer(input header_t h);
		in_valid <= 1'b1;
		func <= h.fn;
		src_addr <= h.sa;
		dst_addr <= h.da;
		src_port <= h.sp;
		dst_port <= h.dp;
		proto_kind <= h.pk;
		tcp_flag_bits <= h.fl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (($urandom % 100) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function automatic header_t make_header(logic fn, logic [31:0] sa, logic [31:0] da,
		logic [15:0] sp, logic [15:0] dp, logic [1:0] pk, logic [7:0] fl);
		header_t h;
		h.fn = fn; h.sa = sa; h.da = da; h.sp = sp; h.dp = dp; h.pk = pk; h.fl = fl;
		return h;
	endfunction

	function automatic header_t random_header();
		header_t h;
		int      r;
		logic [31:0] t32;
		logic [15:0] t16;
		r = $urandom % 1000;
		if (r < 8) return make_header(1'b1, $urandom, $urandom, 16'($urandom),
			16'($urandom), 2'($urandom), 8'($urandom));
		if (r < 600 && flow_pool.size() > 0) begin
			h = flow_pool[$urandom % flow_pool.size()];
			if ($urandom % 2) begin
				t32 = h.sa; h.sa = h.da; h.da = t32;
				t16 = h.sp; h.sp = h.dp; h.dp = t16;
			end
			if ($urandom % 10 == 0) h.pk = 2'($urandom);
			h.fl = ($urandom % 3 == 0) ? 8'($urandom) : 8'(8'h1 << $urandom_range(0, 4));
			return h;
		end
		if ($urandom % 3 == 0)
			h = make_header(1'b0, $urandom_range(0, 15), $urandom_range(0, 3),
				16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 2'($urandom),
				8'($urandom));
		else
			h = make_header(1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom),
				2'($urandom), 8'($urandom));
		flow_pool.push_back(h);
		if (flow_pool.size() > 48) void'(flow_pool.pop_front());
		return h;
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 256; i++)
			offer(make_header(1'b0, i, 32'd0, 16'd0, 16'd0, PK_UDP, 8'h00));
		offer(make_header(1'b0, 32'd300, 32'd0, 16'd0, 16'd0, PK_UDP, 8'h00));
		offer(make_header(1'b0, 32'd5, 32'd0, 16'd0, 16'd0, PK_UDP, 8'h00));
		offer(make_header(1'b1, '1, '1, '1, '1, 2'd3, 8'hFF));
		offer(make_header(1'b0, '1, '1, '1, '1, 2'd3, 8'hFF));
		offer(make_header(1'b0, '1, '1, '1, '1, 2'd0, 8'h00));
		offer(make_header(1'b0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PK_TCP, 8'h02));
		offer(make_header(1'b0, 32'h0A000002, 32'h0A000001, 16'd80, 16'd1234, PK_TCP, 8'h12));
		offer(make_header(1'b0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PK_TCP, 8'h18));
		offer(make_header(1'b0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PK_TCP, 8'h10));
		offer(make_header(1'b0, 32'h0A000002, 32'h0A000001, 16'd80, 16'd1234, PK_TCP, 8'h11));
		offer(make_header(1'b0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PK_TCP, 8'h10));
		offer(make_header(1'b0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PK_TCP, 8'hE0));
		offer(make_header(1'b0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PK_TCP, 8'h1F));
		offer(make_header(1'b0, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PK_UDP, 8'h04));
		offer(make_header(1'b0, 32'h0A000002, 32'h0A000001, 16'd80, 16'd1234, PK_UDP, 8'h04));
		offer(make_header(1'b0, 32'h0, 32'h0, 16'h0, 16'h0, PK_TCP, 8'h08));
		offer(make_header(1'b0, 32'h0, 32'h0, 16'hFFFF, 16'h0, PK_TCP, 8'h01));
		offer(make_header(1'b1, '0, '0, '0, '0, 2'd0, 8'h00));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 62; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 62; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			for (int i = 0; i < 400; i++) begin
				if (ph == 0 && i == 200) hold_req = 1;
				offer(random_header());
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0) $display("bidirectional_flow_table_core: match");
		else $display("bidirectional_flow_table_core: mismatch");
		$finish;
	end

endmodule
